@@ rtl/led_cube_frame_buffer_scanner_core_macros.svh @@
// Assertion macros for the LED cube frame buffer scanner.
// Included by the top level; depends on nothing else.
`ifndef LED_CUBE_FRAME_BUFFER_SCANNER_CORE_MACROS_SVH
`define LED_CUBE_FRAME_BUFFER_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LCFBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcfbs assertion failed");

// Plain invariant, disabled while reset is held.
`define LCFBS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("lcfbs invariant failed");

`endif

@@ rtl/lcfbs_pkg.sv @@
// Shared constants, operation codes and the frame store request type.
// Used by lcfbs_store, led_cube_frame_buffer_scanner_core and the testbench; no dependencies.
package lcfbs_pkg;

    localparam int SIDE     = 8;
    localparam int LAYERS   = 8;
    localparam int COORD_W  = $clog2(SIDE);
    localparam int LCNT_W   = 4;
    localparam int WORD_W   = 8;
    localparam int ADDR_W   = 1 + 2 * COORD_W;
    localparam int DEPTH    = 1 << ADDR_W;

    typedef enum logic [3:0] {
        FN_SETVOX  = 4'd0,
        FN_CLRVOX  = 4'd1,
        FN_WRVOX   = 4'd2,
        FN_GETVOX  = 4'd3,
        FN_GETX    = 4'd4,
        FN_SETX    = 4'd5,
        FN_GETY    = 4'd6,
        FN_SETY    = 4'd7,
        FN_GETZ    = 4'd8,
        FN_SETZ    = 4'd9,
        FN_READY   = 4'd10,
        FN_ELAPSED = 4'd11,
        FN_TICK    = 4'd12,
        FN_START   = 4'd13,
        FN_STOP    = 4'd14
    } func_t;

    // One write port and one read port of the frame store per cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

@@ rtl/led_cube_frame_buffer_scanner_core.sv @@
// Top level of the double-buffered LED cube frame buffer and layer scanner.
// Depends on lcfbs_pkg, lcfbs_store and the assertion macro header.
//
//  channel | direction | tdata (low bit up)                      | tuser       | tlast
//  s_      | request   | func, coord_x, coord_y, coord_z, w_data | -           | -
//  m_      | result    | status, read_data, shift_byte           | shift_valid | latch_last
//
// After reset a clearing pass writes zeros through all 128 store words with s_tready
// low. Flag and mode requests and row writes along X are done in the decode state
// without a store read; single voxel ops, reads along X, axis ops along Y or Z and
// running ticks take a read and a data state for every stored word they touch on the
// single store read port. Results wait in one output register; a stalled m_ side
// holds the sequencer at its next result.
`include "led_cube_frame_buffer_scanner_core_macros.svh"

module led_cube_frame_buffer_scanner_core import lcfbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[3:0], coord_x[11:4], coord_y[19:12],
                                   // coord_z[27:20], write_data[35:28], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[0], read_data[8:1], shift_byte[16:9], zero pad
    output logic        m_tuser,   // shift_valid
    output logic        m_tlast    // latch_last
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_LAYER, ST_READ, ST_DATA, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_READY, MODE_RUNNING, MODE_STOPPED
    } mode_t;

    localparam logic [COORD_W-1:0] IDX_LAST = COORD_W'(SIDE - 1);
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(DEPTH - 1);

    state_t              state_reg;
    mode_t               mode_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    func_t               func_reg;
    logic [7:0]          cx_reg, cy_reg, cz_reg, wd_reg;
    logic [COORD_W-1:0]  idx_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic                front_reg;
    logic [LCNT_W-1:0]   layer_cnt_reg;
    logic                ready_flag_reg, elapsed_flag_reg;
    logic                res_st_reg;
    logic [7:0]          res_rd_reg;
    logic                m_tvalid_reg, st_out_reg, sv_out_reg, last_out_reg;
    logic [7:0]          rd_out_reg, sb_out_reg;

    logic                okx, oky, okz, item_ok, out_free, is_write, wr_bit;
    logic [COORD_W-1:0]  cx, ysel, zsel, layer;
    logic [WORD_W-1:0]   rdata, new_word, acc_next;
    logic [ADDR_W-1:0]   addr;
    mem_req_t            req;

    assign okx = cx_reg < 8'(SIDE);
    assign oky = cy_reg < 8'(SIDE);
    assign okz = cz_reg < 8'(SIDE);
    assign cx  = cx_reg[COORD_W-1:0];

    always_comb begin
        case (func_reg)
            FN_SETVOX, FN_CLRVOX, FN_WRVOX, FN_GETVOX: item_ok = okx && oky && okz;
            FN_GETX, FN_SETX:                          item_ok = oky && okz;
            FN_GETY, FN_SETY:                          item_ok = okx && okz;
            FN_GETZ, FN_SETZ:                          item_ok = okx && oky;
            FN_READY, FN_ELAPSED, FN_TICK, FN_STOP:    item_ok = mode_reg == MODE_RUNNING;
            FN_START: item_ok = (mode_reg == MODE_READY) || (mode_reg == MODE_STOPPED);
            default:                                   item_ok = 1'b0;
        endcase
    end

    // Row word selection: the loop index walks y or z depending on the operation.
    always_comb begin
        ysel = cy_reg[COORD_W-1:0];
        zsel = cz_reg[COORD_W-1:0];
        case (func_reg)
            FN_GETY, FN_SETY, FN_TICK: ysel = idx_reg;
            FN_GETZ, FN_SETZ:          zsel = idx_reg;
            default:                   ysel = cy_reg[COORD_W-1:0];
        endcase
    end

    always_comb begin
        case (func_reg)
            FN_SETVOX, FN_CLRVOX, FN_WRVOX, FN_SETX, FN_SETY, FN_SETZ: is_write = 1'b1;
            default:                                                    is_write = 1'b0;
        endcase
    end

    always_comb begin
        case (func_reg)
            FN_SETVOX:        wr_bit = 1'b1;
            FN_CLRVOX:        wr_bit = 1'b0;
            FN_WRVOX:         wr_bit = wd_reg[0];
            FN_SETY, FN_SETZ: wr_bit = wd_reg[idx_reg];
            default:          wr_bit = 1'b0;
        endcase
    end

    // Writes go to the back buffer, reads come from the front buffer.
    assign addr     = {is_write ? ~front_reg : front_reg, ysel, zsel};
    assign new_word = (rdata & ~(WORD_W'(1) << cx)) | (WORD_W'(wr_bit) << cx);
    assign acc_next = acc_reg | (WORD_W'(rdata[cx]) << idx_reg);
    assign layer    = cz_reg[COORD_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        req.we    = 1'b0;
        req.waddr = addr;
        req.wdata = new_word;
        req.re    = state_reg == ST_READ;
        req.raddr = addr;
        case (state_reg)
            ST_CLEAR: begin
                req.we    = 1'b1;
                req.waddr = clr_cnt_reg;
                req.wdata = '0;
            end
            ST_DECODE: begin
                req.we    = (func_reg == FN_SETX) && item_ok;
                req.wdata = wd_reg;
            end
            ST_DATA: begin
                req.we = is_write;
            end
            default: req.we = 1'b0;
        endcase
    end

    lcfbs_store u_store (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            mode_reg         <= MODE_READY;
            front_reg        <= 1'b0;
            layer_cnt_reg    <= '0;
            ready_flag_reg   <= 1'b0;
            elapsed_flag_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= func_t'(s_tdata[3:0]);
                        cx_reg    <= s_tdata[11:4];
                        cy_reg    <= s_tdata[19:12];
                        cz_reg    <= s_tdata[27:20];
                        wd_reg    <= s_tdata[35:28];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    res_st_reg <= 1'b0;
                    res_rd_reg <= '0;
                    idx_reg    <= '0;
                    acc_reg    <= '0;
                    state_reg  <= ST_EMIT;
                    if (!item_ok) begin
                        res_st_reg <= 1'b1;
                    end else begin
                        case (func_reg)
                            FN_SETX:    ;
                            FN_READY:   ready_flag_reg   <= 1'b1;
                            FN_ELAPSED: elapsed_flag_reg <= 1'b1;
                            FN_START:   mode_reg         <= MODE_RUNNING;
                            FN_STOP:    mode_reg         <= MODE_STOPPED;
                            FN_TICK: begin
                                // On wrap, swap buffers once both flags are up.
                                if (layer_cnt_reg >= LCNT_W'(LAYERS)) begin
                                    layer_cnt_reg <= LCNT_W'(1);
                                    cz_reg        <= '0;
                                    if (ready_flag_reg && elapsed_flag_reg) begin
                                        front_reg        <= ~front_reg;
                                        ready_flag_reg   <= 1'b0;
                                        elapsed_flag_reg <= 1'b0;
                                    end
                                end else begin
                                    layer_cnt_reg <= layer_cnt_reg + 1'b1;
                                    cz_reg        <= 8'(layer_cnt_reg);
                                end
                                state_reg <= ST_LAYER;
                            end
                            default: state_reg <= ST_READ;
                        endcase
                    end
                end
                ST_LAYER: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        st_out_reg   <= 1'b0;
                        rd_out_reg   <= '0;
                        sb_out_reg   <= 8'(1) << layer;
                        sv_out_reg   <= 1'b1;
                        last_out_reg <= 1'b0;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_DATA;
                end
                ST_DATA: begin
                    case (func_reg)
                        FN_GETVOX: begin
                            res_rd_reg <= 8'(rdata[cx]);
                            state_reg  <= ST_EMIT;
                        end
                        FN_GETX: begin
                            res_rd_reg <= rdata;
                            state_reg  <= ST_EMIT;
                        end
                        FN_GETY, FN_GETZ: begin
                            acc_reg <= acc_next;
                            idx_reg <= idx_reg + 1'b1;
                            if (idx_reg == IDX_LAST) begin
                                res_rd_reg <= acc_next;
                                state_reg  <= ST_EMIT;
                            end else begin
                                state_reg <= ST_READ;
                            end
                        end
                        FN_SETY, FN_SETZ: begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= (idx_reg == IDX_LAST) ? ST_EMIT : ST_READ;
                        end
                        FN_TICK: begin
                            if (out_free) begin
                                m_tvalid_reg <= 1'b1;
                                st_out_reg   <= 1'b0;
                                rd_out_reg   <= '0;
                                sb_out_reg   <= rdata;
                                sv_out_reg   <= 1'b1;
                                last_out_reg <= idx_reg == IDX_LAST;
                                idx_reg      <= idx_reg + 1'b1;
                                state_reg    <= (idx_reg == IDX_LAST) ? ST_IDLE : ST_READ;
                            end
                        end
                        default: state_reg <= ST_EMIT;
                    endcase
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        st_out_reg   <= res_st_reg;
                        rd_out_reg   <= res_rd_reg;
                        sb_out_reg   <= '0;
                        sv_out_reg   <= 1'b0;
                        last_out_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, sb_out_reg, rd_out_reg, st_out_reg};
    assign m_tuser  = sv_out_reg;
    assign m_tlast  = last_out_reg;

    // A buffer swap happens only with both flags set, which it then clears.
    `LCFBS_ASSERT_NOW(a_swap_needs_flags, front_reg != $past(front_reg), $past(ready_flag_reg && elapsed_flag_reg) && !ready_flag_reg && !elapsed_flag_reg)
    // The frame-ready flag can only come up while the scanner runs.
    `LCFBS_ASSERT_NOW(a_flag_only_running, $rose(ready_flag_reg), mode_reg == MODE_RUNNING)
    // The layer counter never runs past one beyond the last layer.
    `LCFBS_ASSERT_ALWAYS(a_layer_bound, layer_cnt_reg <= LCNT_W'(LAYERS))

endmodule

@@ rtl/lcfbs_store.sv @@
// Frame store for both buffers: one write and one registered read per cycle.
// Depends on lcfbs_pkg.
module lcfbs_store import lcfbs_pkg::*; (
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        // Read data holds while no read is issued.
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/led_cube_frame_buffer_scanner_core_test.sv @@
// Testbench for the LED cube frame buffer scanner: a scoreboard class that predicts
// every result from its own copy of both frames, and a top module that drives requests.
// Depends on lcfbs_pkg and led_cube_frame_buffer_scanner_core.
import lcfbs_pkg::*;

typedef enum logic [1:0] {
    MODE_READY,
    MODE_RUNNING,
    MODE_STOPPED
} scan_mode_t;

typedef struct {
    logic [3:0] func;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] wd;
} cube_request_t;

typedef struct {
    logic       status;
    logic [7:0] read_data;
    logic [7:0] shift_byte;
    logic       shift_valid;
    logic       latch_last;
} cube_result_t;

class cube_scan_scoreboard;
    logic [7:0]   frames [128];
    bit           front_buf;
    bit [3:0]     layer_cnt;
    bit           frame_ready;
    bit           time_elapsed;
    scan_mode_t   mode;
    cube_result_t pending [$];
    int           mismatches;

    function new();
        foreach (frames[i]) frames[i] = '0;
        front_buf    = 1'b0;
        layer_cnt    = '0;
        frame_ready  = 1'b0;
        time_elapsed = 1'b0;
        mode         = MODE_READY;
        mismatches   = 0;
    endfunction

    // Bit x of a word is voxel (x, y, z); the buffer number is the top address bit.
    function int word_index(bit b, logic [7:0] y, logic [7:0] z);
        return {b, y[2:0], z[2:0]};
    endfunction

    function void push(logic st, logic [7:0] rd, logic [7:0] sb, logic sv, logic ll);
        cube_result_t res;
        res.status      = st;
        res.read_data   = rd;
        res.shift_byte  = sb;
        res.shift_valid = sv;
        res.latch_last  = ll;
        pending.push_back(res);
    endfunction

    function void note_request(cube_request_t r);
        bit         fr;
        bit         bk;
        bit         okx;
        bit         oky;
        bit         okz;
        logic       st;
        logic [7:0] rd;
        logic       on;
        int         w;
        int         layer;
        fr  = front_buf;
        bk  = ~front_buf;
        okx = r.x < SIDE;
        oky = r.y < SIDE;
        okz = r.z < SIDE;
        st  = 1'b0;
        rd  = '0;
        case (r.func)
            FN_SETVOX, FN_CLRVOX, FN_WRVOX: begin
                if (okx && oky && okz) begin
                    on = (r.func == FN_SETVOX) ? 1'b1 :
                         (r.func == FN_CLRVOX) ? 1'b0 : r.wd[0];
                    w = word_index(bk, r.y, r.z);
                    frames[w][r.x[2:0]] = on;
                end else begin
                    st = 1'b1;
                end
            end
            FN_GETVOX: begin
                if (okx && oky && okz) rd = frames[word_index(fr, r.y, r.z)][r.x[2:0]];
                else st = 1'b1;
            end
            FN_GETX: begin
                if (oky && okz) rd = frames[word_index(fr, r.y, r.z)];
                else st = 1'b1;
            end
            FN_SETX: begin
                if (oky && okz) frames[word_index(bk, r.y, r.z)] = r.wd;
                else st = 1'b1;
            end
            FN_GETY, FN_GETZ: begin
                if (okx && ((r.func == FN_GETY) ? okz : oky)) begin
                    for (int i = 0; i < SIDE; i++) begin
                        w = (r.func == FN_GETY) ? word_index(fr, i, r.z) : word_index(fr, r.y, i);
                        rd[i] = frames[w][r.x[2:0]];
                    end
                end else begin
                    st = 1'b1;
                end
            end
            FN_SETY, FN_SETZ: begin
                if (okx && ((r.func == FN_SETY) ? okz : oky)) begin
                    for (int i = 0; i < SIDE; i++) begin
                        w = (r.func == FN_SETY) ? word_index(bk, i, r.z) : word_index(bk, r.y, i);
                        frames[w][r.x[2:0]] = r.wd[i];
                    end
                end else begin
                    st = 1'b1;
                end
            end
            FN_READY: begin
                if (mode == MODE_RUNNING) frame_ready = 1'b1;
                else st = 1'b1;
            end
            FN_ELAPSED: begin
                if (mode == MODE_RUNNING) time_elapsed = 1'b1;
                else st = 1'b1;
            end
            FN_TICK: begin
                if (mode == MODE_RUNNING) begin
                    // The swap is only considered when the layer count wraps.
                    if (layer_cnt >= LAYERS) begin
                        layer_cnt = '0;
                        if (frame_ready && time_elapsed) begin
                            front_buf    = ~front_buf;
                            frame_ready  = 1'b0;
                            time_elapsed = 1'b0;
                        end
                    end
                    layer = layer_cnt[2:0];
                    push(1'b0, 8'h00, 8'h01 << layer, 1'b1, 1'b0);
                    for (int i = 0; i < SIDE; i++)
                        push(1'b0, 8'h00, frames[word_index(front_buf, i, layer)], 1'b1,
                             i == SIDE - 1);
                    layer_cnt = layer_cnt + 1;
                    return;
                end
                st = 1'b1;
            end
            FN_START: begin
                if (mode == MODE_READY || mode == MODE_STOPPED) mode = MODE_RUNNING;
                else st = 1'b1;
            end
            FN_STOP: begin
                if (mode == MODE_RUNNING) mode = MODE_STOPPED;
                else st = 1'b1;
            end
            default: st = 1'b1;
        endcase
        push(st, st ? 8'h00 : rd, 8'h00, 1'b0, 1'b1);
    endfunction

    function void check_result(cube_result_t act);
        cube_result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result st=%0d rd=%h sb=%h sv=%0d ll=%0d", $time,
                     act.status, act.read_data, act.shift_byte, act.shift_valid,
                     act.latch_last);
            return;
        end
        want = pending.pop_front();
        if (want.status !== act.status || want.read_data !== act.read_data ||
            want.shift_byte !== act.shift_byte || want.shift_valid !== act.shift_valid ||
            want.latch_last !== act.latch_last) begin
            mismatches++;
            $display("%0t: expected st=%0d rd=%h sb=%h sv=%0d ll=%0d, got st=%0d rd=%h sb=%h sv=%0d ll=%0d",
                     $time, want.status, want.read_data, want.shift_byte, want.shift_valid,
                     want.latch_last, act.status, act.read_data, act.shift_byte,
                     act.shift_valid, act.latch_last);
        end
    endfunction

    function int outstanding();
        return pending.size();
    endfunction
endclass

module led_cube_frame_buffer_scanner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQUESTS = 205;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    cube_scan_scoreboard sb;
    int                  cycle_count = 0;
    bit                  send_burst = 1'b0;

    led_cube_frame_buffer_scanner_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // A request stays valid without a gap when the next one follows at once.
    task automatic send_request(logic [3:0] func, logic [7:0] x, logic [7:0] y,
                                logic [7:0] z, logic [7:0] wd);
        cube_request_t r;
        int            gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, wd, z, y, x, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r.func = func;
        r.x    = x;
        r.y    = y;
        r.z    = z;
        r.wd   = wd;
        sb.note_request(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() > 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_coord();
        if ($urandom_range(0, 99) < 88) return $urandom_range(0, 7);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [3:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return FN_SETVOX;
        if (r < 9)  return FN_CLRVOX;
        if (r < 13) return FN_WRVOX;
        if (r < 17) return FN_GETVOX;
        if (r < 20) return FN_GETX;
        if (r < 26) return FN_SETX;
        if (r < 29) return FN_GETY;
        if (r < 33) return FN_SETY;
        if (r < 36) return FN_GETZ;
        if (r < 40) return FN_SETZ;
        if (r < 48) return FN_READY;
        if (r < 56) return FN_ELAPSED;
        if (r < 84) return FN_TICK;
        if (r < 91) return FN_START;
        if (r < 95) return FN_STOP;
        return 4'hF;
    endfunction

    // Result side: a fresh stall is drawn for every result, with stall-free stretches.
    initial begin
        cube_result_t act;
        int           stall;
        bit           fast;
        fast = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) fast = ~fast;
            stall = fast ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            act.status      = m_tdata[0];
            act.read_data   = m_tdata[8:1];
            act.shift_byte  = m_tdata[16:9];
            act.shift_valid = m_tuser;
            act.latch_last  = m_tlast;
            sb.check_result(act);
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: edges of the coordinates, every operation, every mode error.
        send_request(FN_GETVOX,  8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_SETVOX,  8'd7,   8'd7,   8'd7,   8'h00);
        send_request(FN_SETVOX,  8'd8,   8'd0,   8'd0,   8'h00);
        send_request(FN_CLRVOX,  8'd0,   8'd255, 8'd0,   8'hFF);
        send_request(FN_WRVOX,   8'd3,   8'd4,   8'd5,   8'h01);
        send_request(FN_GETX,    8'd0,   8'd8,   8'd0,   8'h00);
        send_request(FN_SETX,    8'd255, 8'd7,   8'd0,   8'hA5);
        send_request(FN_SETY,    8'd7,   8'd0,   8'd7,   8'hFF);
        send_request(FN_SETZ,    8'd0,   8'd7,   8'd0,   8'h81);
        send_request(FN_GETY,    8'd7,   8'd0,   8'd7,   8'h00);
        send_request(FN_GETZ,    8'd0,   8'd7,   8'd0,   8'h00);
        send_request(FN_GETVOX,  8'd0,   8'd0,   8'd255, 8'h00);
        send_request(FN_READY,   8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_ELAPSED, 8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_TICK,    8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_STOP,    8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_START,   8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_START,   8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_READY,   8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_ELAPSED, 8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_TICK,    8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_STOP,    8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_START,   8'd0,   8'd0,   8'd0,   8'h00);
        send_request(4'hF,       8'd0,   8'd0,   8'd0,   8'h00);
        send_request(FN_GETY,    8'd8,   8'd0,   8'd0,   8'h00);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
            if (n % 60 == 59) drain_results();
            send_request(pick_func(), pick_coord(), pick_coord(), pick_coord(),
                         $urandom_range(0, 255));
        end
        drain_results();
        repeat (40) @(posedge aclk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
